@@ src/aup_pkg.sv @@
package aup_pkg;

  localparam int CHAN_W    = 8;
  localparam int DIVD_W    = 2 * CHAN_W;
  localparam int DIV_STEPS = CHAN_W + 1;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  typedef logic [1:0] chan_sel_t;
  localparam chan_sel_t CH_RED   = 2'd0;
  localparam chan_sel_t CH_GREEN = 2'd1;
  localparam chan_sel_t CH_BLUE  = 2'd2;

  typedef struct packed {
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_alpha;
    logic              in_last;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_alpha;
    logic              frame_translucent;
    logic              out_last;
  } pix_out_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [CHAN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [CHAN_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ src/aup_stream_if.sv @@
interface aup_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/aup_divider.sv @@
// Restoring divider, one quotient bit per cycle. The first step only checks
// for a quotient above the channel range; the next eight give the quotient.
module aup_divider (
  input  logic             clk,
  input  logic             rst,
  input  aup_pkg::div_req_t req,
  output aup_pkg::div_rsp_t rsp
);
  import aup_pkg::*;

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [CHAN_W:0]     rem;
  logic [CHAN_W-1:0]   low;
  logic [CHAN_W-1:0]   quot;
  logic [CHAN_W-1:0]   dvs;
  logic                sat;
  logic [CHAN_W:0]     trial;
  logic [CHAN_W+1:0]   diff;
  logic                ge;
  logic                last_step;

  always_comb begin
    trial     = (step == '0) ? rem : {rem[CHAN_W-1:0], low[CHAN_W-1]};
    diff      = {1'b0, trial} - {2'b00, dvs};
    ge        = !diff[CHAN_W+1];
    last_step = busy && (step == STEP_W'(DIV_STEPS - 1));
  end

  assign rsp.busy = busy;
  assign rsp.done = last_step;
  assign rsp.quot = sat ? CHAN_MAX : {quot[CHAN_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (last_step) begin
      busy <= 1'b0;
    end else if (busy) begin
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= {1'b0, req.dividend[DIVD_W-1:CHAN_W]};
      low  <= req.dividend[CHAN_W-1:0];
      dvs  <= req.divisor;
      sat  <= 1'b0;
      quot <= '0;
    end else if (busy) begin
      if (step == '0) begin
        // high byte already >= divisor: quotient cannot fit a channel
        sat <= ge;
      end else begin
        rem  <= ge ? diff[CHAN_W:0] : trial;
        low  <= {low[CHAN_W-2:0], 1'b0};
        quot <= {quot[CHAN_W-2:0], ge};
      end
    end
  end

endmodule

@@ src/alpha_unpremultiply_stream_core.sv @@
// Alpha 1..254 pixels are divided channel by channel (red, green, blue) in the
//   single restoring divider; alpha 0, alpha 255 and background fill bypass it.
// A new pixel is accepted only once the previous result has been loaded into
//   the output register.
// Reset (rst, synchronous): clears the sequencer, output valid, the sticky
//   translucency flag and the background fill register.
module alpha_unpremultiply_stream_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic         cfg_wdata,
  aup_stream_if.sink   pixel,
  aup_stream_if.source result
);
  import aup_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t            state;
  logic              bg_fill;
  logic              seen;
  pix_in_t           px;
  logic              flag;
  chan_sel_t         chan;
  logic [CHAN_W-1:0] res_r;
  logic [CHAN_W-1:0] res_g;
  logic [CHAN_W-1:0] res_b;

  logic              accept;
  logic              bypass_in;
  logic              flag_in;
  logic              out_free;
  logic [CHAN_W-1:0] c_sel;
  logic [CHAN_W-1:0] a_sel;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign pixel.ready = (state == S_IDLE);
  assign accept      = pixel.valid && pixel.ready;
  assign out_free    = !result.valid || result.ready;

  always_comb begin
    bypass_in = bg_fill || (pixel.data.in_alpha == '0) || (pixel.data.in_alpha == CHAN_MAX);
    flag_in   = !bg_fill && (seen || (pixel.data.in_alpha != CHAN_MAX));
    if (accept) begin
      c_sel = pixel.data.in_red;
      a_sel = pixel.data.in_alpha;
    end else begin
      c_sel = (chan == CH_RED) ? px.in_green : px.in_blue;
      a_sel = px.in_alpha;
    end
    div_req.start    = (accept && !bypass_in) ||
                       ((state == S_DIV) && div_rsp.done && (chan != CH_BLUE));
    // c*255 + a/2
    div_req.dividend = {c_sel, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, c_sel}
                       + {{(CHAN_W+1){1'b0}}, a_sel[CHAN_W-1:1]};
    div_req.divisor  = a_sel;
  end

  aup_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_fill <= 1'b0;
    end else if (cfg_wen) begin
      bg_fill <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      seen         <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (accept) begin
        seen <= pixel.data.in_last ? 1'b0 : flag_in;
      end
      if ((state == S_OUT) && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= bypass_in ? S_OUT : S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done && (chan == CH_BLUE)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px   <= pixel.data;
      flag <= flag_in;
      chan <= CH_RED;
      if (pixel.data.in_alpha == '0 && !bg_fill) begin
        res_r <= '0;
        res_g <= '0;
        res_b <= '0;
      end else begin
        res_r <= pixel.data.in_red;
        res_g <= pixel.data.in_green;
        res_b <= pixel.data.in_blue;
      end
    end else if ((state == S_DIV) && div_rsp.done) begin
      chan <= chan + 1'b1;
      case (chan)
        CH_RED:   res_r <= div_rsp.quot;
        CH_GREEN: res_g <= div_rsp.quot;
        default:  res_b <= div_rsp.quot;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      result.data.out_red           <= res_r;
      result.data.out_green         <= res_g;
      result.data.out_blue          <= res_b;
      result.data.out_alpha         <= px.in_alpha;
      result.data.frame_translucent <= flag;
      result.data.out_last          <= px.in_last;
    end
  end

  a_blue_done_to_out: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIV) && div_rsp.done && (chan == CH_BLUE)) |=> (state == S_OUT))
    else $error("blue quotient did not move sequencer to output");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> (!div_rsp.busy || div_rsp.done))
    else $error("divider restarted mid-division");

  a_last_clears_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && pixel.data.in_last) |=> !seen)
    else $error("translucency flag not cleared after last pixel");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> (state == S_DIV))
    else $error("divider busy outside divide state");

endmodule

@@ test/tb.sv @@
module tb;
  import aup_pkg::*;

  typedef enum logic {ROW_PIXEL, ROW_FILL} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TRICKLE} rx_mode_t;

  typedef struct {
    row_kind_t kind;
    logic      fill;
    pix_in_t   px;
    logic      known;
    pix_out_t  want;
  } dir_row_t;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst = 1'b1;
  logic cfg_wen;
  logic cfg_wdata;

  aup_stream_if #(.payload_t(pix_in_t))  pixel_if ();
  aup_stream_if #(.payload_t(pix_out_t)) result_if ();

  alpha_unpremultiply_stream_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .pixel     (pixel_if),
    .result    (result_if)
  );

  // predictor state
  logic fill_q;
  logic translucent_q;

  pix_out_t pending_pixels[$];
  int       mismatch_count;
  bit       hold_req;
  bit       hold_active;
  bit       hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("** alpha_unpremultiply_stream_core: FAILED **");
    $finish;
  end

  function automatic logic [7:0] unpremultiply_chan(logic [7:0] c, logic [7:0] a);
    logic [16:0] q;
    if (a == 8'd0) return 8'd0;
    if (a == CHAN_MAX) return c;
    q = ({9'd0, c} * 17'd255 + {10'd0, a[7:1]}) / {9'd0, a};
    return (q > 17'd255) ? CHAN_MAX : q[7:0];
  endfunction

  function automatic pix_out_t unpremultiply_pixel(pix_in_t p);
    pix_out_t o;
    if (fill_q) begin
      translucent_q = 1'b0;
      o.out_red   = p.in_red;
      o.out_green = p.in_green;
      o.out_blue  = p.in_blue;
    end else begin
      if (p.in_alpha != CHAN_MAX) translucent_q = 1'b1;
      o.out_red   = unpremultiply_chan(p.in_red, p.in_alpha);
      o.out_green = unpremultiply_chan(p.in_green, p.in_alpha);
      o.out_blue  = unpremultiply_chan(p.in_blue, p.in_alpha);
    end
    o.out_alpha         = p.in_alpha;
    o.frame_translucent = translucent_q;
    o.out_last          = p.in_last;
    if (p.in_last) translucent_q = 1'b0;
    return o;
  endfunction

  // mostly well-formed premultiplied colour (c <= a), sometimes anything
  function automatic logic [7:0] rand_chan(logic [7:0] a);
    if (a != 8'd0 && $urandom_range(0, 3) != 0) return 8'($urandom_range(0, a));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic pix_in_t rand_pixel(logic last);
    pix_in_t p;
    case ($urandom_range(0, 9))
      0:       p.in_alpha = 8'd0;
      1, 2:    p.in_alpha = CHAN_MAX;
      3: begin
        case ($urandom_range(0, 2))
          0:       p.in_alpha = 8'd1;
          1:       p.in_alpha = 8'd2;
          default: p.in_alpha = 8'd254;
        endcase
      end
      default: p.in_alpha = 8'($urandom_range(1, 254));
    endcase
    p.in_red   = rand_chan(p.in_alpha);
    p.in_green = rand_chan(p.in_alpha);
    p.in_blue  = rand_chan(p.in_alpha);
    p.in_last  = last;
    return p;
  endfunction

  function void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // leaves valid high; the caller lowers it for a gap
  task automatic send_pixel(input pix_in_t p, input logic known, input pix_out_t want);
    pix_out_t guess;
    pixel_if.valid <= 1'b1;
    pixel_if.data  <= p;
    do @(posedge clk); while (!(pixel_if.valid === 1'b1 && pixel_if.ready === 1'b1));
    guess = unpremultiply_pixel(p);
    pending_pixels.push_back(known ? want : guess);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      pixel_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_fill(input logic v);
    pixel_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    fill_q  = v;
  endtask

  // result checker
  pix_out_t got_pix;
  pix_out_t want_pix;

  always @(posedge clk) begin
    if (!rst && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      got_pix = result_if.data;
      if (pending_pixels.size() == 0) begin
        $display("%0t: result expected none, got %h", $time, got_pix);
        mismatch_count++;
      end else begin
        want_pix = pending_pixels.pop_front();
        check_field("red", want_pix.out_red, got_pix.out_red);
        check_field("green", want_pix.out_green, got_pix.out_green);
        check_field("blue", want_pix.out_blue, got_pix.out_blue);
        check_field("alpha", want_pix.out_alpha, got_pix.out_alpha);
        check_field("translucent", 8'(want_pix.frame_translucent),
                    8'(got_pix.frame_translucent));
        check_field("last", 8'(want_pix.out_last), 8'(got_pix.out_last));
      end
    end
  end

  // receiver: stall pattern changes every span, plus one long hold-off
  initial begin
    rx_mode_t mode;
    int       span;
    result_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req && !hold_done) begin
        hold_active = 1'b1;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done   = 1'b1;
        hold_active = 1'b0;
      end
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 96);
      repeat (span) begin
        case (mode)
          RX_OPEN:    result_if.ready <= 1'b1;
          RX_COIN:    result_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:  result_if.ready <= ($urandom_range(0, 3) == 0);
          RX_TRICKLE: result_if.ready <= ($urandom_range(0, 15) == 0);
          default:    result_if.ready <= 1'b1;
        endcase
        @(posedge clk);
      end
    end
  end

  // stimulus
  initial begin
    dir_row_t dir_rows[$];
    int       burst_left;
    int       sent;
    int       frame_len;
    int       gap;

    pixel_if.valid <= 1'b0;
    pixel_if.data  <= '0;
    cfg_wen        <= 1'b0;
    cfg_wdata      <= 1'b0;
    fill_q         = 1'b0;
    translucent_q  = 1'b0;
    mismatch_count = 0;
    hold_req       = 1'b0;
    hold_active    = 1'b0;
    hold_done      = 1'b0;

    dir_rows = '{
      '{ROW_PIXEL, 1'b0, {8'h10, 8'h20, 8'h30, 8'hff, 1'b0}, 1'b1,
        {8'h10, 8'h20, 8'h30, 8'hff, 1'b0, 1'b0}},
      '{ROW_PIXEL, 1'b0, {8'hff, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b1,
        {8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1}},
      '{ROW_PIXEL, 1'b0, {8'h00, 8'h00, 8'h00, 8'hff, 1'b0}, 1'b1,
        {8'h00, 8'h00, 8'h00, 8'hff, 1'b0, 1'b0}},
      // zero alpha blanks the colour and sets the flag
      '{ROW_PIXEL, 1'b0, {8'hff, 8'h80, 8'h01, 8'h00, 1'b0}, 1'b1,
        {8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0}},
      '{ROW_PIXEL, 1'b0, {8'h12, 8'h34, 8'h56, 8'hff, 1'b0}, 1'b1,
        {8'h12, 8'h34, 8'h56, 8'hff, 1'b1, 1'b0}},
      '{ROW_PIXEL, 1'b0, {8'hab, 8'hcd, 8'hef, 8'hff, 1'b1}, 1'b1,
        {8'hab, 8'hcd, 8'hef, 8'hff, 1'b1, 1'b1}},
      '{ROW_PIXEL, 1'b0, {8'h01, 8'h00, 8'h01, 8'hff, 1'b0}, 1'b1,
        {8'h01, 8'h00, 8'h01, 8'hff, 1'b0, 1'b0}},
      // saturation and rounding
      '{ROW_PIXEL, 1'b0, {8'h01, 8'h00, 8'h02, 8'h01, 1'b0}, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, {8'h80, 8'h40, 8'hff, 8'h80, 1'b0}, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, {8'hfe, 8'h7f, 8'h00, 8'hfe, 1'b0}, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, {8'h01, 8'h02, 8'hff, 8'h02, 1'b0}, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, {8'h64, 8'hc8, 8'h32, 8'hc8, 1'b1}, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, {8'h07, 8'h05, 8'h03, 8'h0b, 1'b1}, 1'b0, '0},
      // background fill: colours untouched, flag held low
      '{ROW_FILL, 1'b1, '0, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, {8'hff, 8'h80, 8'h01, 8'h00, 1'b0}, 1'b1,
        {8'hff, 8'h80, 8'h01, 8'h00, 1'b0, 1'b0}},
      '{ROW_PIXEL, 1'b0, {8'h12, 8'h34, 8'h56, 8'h80, 1'b0}, 1'b1,
        {8'h12, 8'h34, 8'h56, 8'h80, 1'b0, 1'b0}},
      '{ROW_PIXEL, 1'b0, {8'hff, 8'hff, 8'hff, 8'hff, 1'b1}, 1'b1,
        {8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1}},
      // fill switched on mid-frame drops earlier translucency
      '{ROW_FILL, 1'b0, '0, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, {8'h20, 8'h20, 8'h20, 8'h40, 1'b0}, 1'b0, '0},
      '{ROW_FILL, 1'b1, '0, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, {8'h20, 8'h20, 8'h20, 8'hff, 1'b0}, 1'b1,
        {8'h20, 8'h20, 8'h20, 8'hff, 1'b0, 1'b0}},
      '{ROW_FILL, 1'b0, '0, 1'b0, '0},
      '{ROW_PIXEL, 1'b0, {8'h20, 8'h20, 8'h20, 8'hff, 1'b1}, 1'b1,
        {8'h20, 8'h20, 8'h20, 8'hff, 1'b0, 1'b1}}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_FILL) begin
        write_fill(dir_rows[i].fill);
      end else begin
        send_pixel(dir_rows[i].px, dir_rows[i].known, dir_rows[i].want);
        if ($urandom_range(0, 1) == 0) pause_sender($urandom_range(1, 3));
      end
    end

    burst_left = $urandom_range(1, 16);
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       write_fill(1'b1);
        1:       write_fill(1'b0);
        default: write_fill($urandom_range(0, 3) == 0);
      endcase
      // long receiver hold-off: keep offering so the core backs up
      if (phase == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < 100) begin
        frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 12);
        for (int k = 0; k < frame_len; k++) begin
          send_pixel(rand_pixel(k == frame_len - 1), 1'b0, '0);
          sent++;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (!hold_active && !(hold_req && !hold_done)) pause_sender(gap);
          end
        end
      end
    end

    pixel_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("** alpha_unpremultiply_stream_core: PASSED **");
    end else begin
      $display("** alpha_unpremultiply_stream_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ alpha_unpremultiply_stream_core.f @@
src/aup_pkg.sv
src/aup_stream_if.sv
src/aup_divider.sv
src/alpha_unpremultiply_stream_core.sv
test/tb.sv
